// ----- hdl/ansi_text_terminal_defines.svh -----
// Assertion macros shared by the terminal checks.
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef ANSI_TEXT_TERMINAL_DEFINES_SVH
`define ANSI_TEXT_TERMINAL_DEFINES_SVH

// Check that cond holds in the cycle after trig.
`define ATE_ASSERT_NEXT(name, trig, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("ansi_text_terminal check failed");

// Check that cond holds in the same cycle as trig.
`define ATE_ASSERT_NOW(name, trig, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("ansi_text_terminal check failed");

`endif

// ----- hdl/ate_pkg.sv -----
package ate_pkg;

   // Screen store geometry
   localparam int MaxColumns       = 160;
   localparam int MaxRows          = 64;
   localparam int MinColumns       = 20;
   localparam int MinRows          = 8;
   localparam int ParamBufferBytes = 32;
   localparam int TabSpaces        = 4;

   localparam int StoreCells = MaxColumns * MaxRows;
   localparam int AddrBits   = $clog2(StoreCells);
   localparam int PosBits    = $clog2(ParamBufferBytes);
   localparam int TabBits    = $clog2(TabSpaces + 1);

   // Configuration register indexes
   localparam int          CsrIndexBits = 1;
   localparam logic [0:0]  CsrColumns   = 1'b0;
   localparam logic [0:0]  CsrRows      = 1'b1;

   // Byte codes
   localparam logic [7:0] EscByte     = 8'h1b;
   localparam logic [7:0] LfByte      = 8'h0a;
   localparam logic [7:0] CrByte      = 8'h0d;
   localparam logic [7:0] BsByte      = 8'h08;
   localparam logic [7:0] TabByte     = 8'h09;
   localparam logic [7:0] SpaceByte   = 8'h20;
   localparam logic [7:0] BracketByte = 8'h5b;
   localparam logic [7:0] SemiByte    = 8'h3b;
   localparam logic [7:0] QuestByte   = 8'h3f;
   localparam logic [7:0] Digit0Byte  = 8'h30;
   localparam logic [7:0] Digit9Byte  = 8'h39;
   localparam logic [7:0] FinUp       = 8'h41;
   localparam logic [7:0] FinDown     = 8'h42;
   localparam logic [7:0] FinRight    = 8'h43;
   localparam logic [7:0] FinLeft     = 8'h44;
   localparam logic [7:0] FinHome     = 8'h48;
   localparam logic [7:0] FinHomeAlt  = 8'h66;
   localparam logic [7:0] FinEraseDsp = 8'h4a;
   localparam logic [7:0] FinEraseLn  = 8'h4b;
   localparam logic [7:0] FinSgr      = 8'h6d;
   localparam logic [7:0] FinSet      = 8'h68;
   localparam logic [7:0] FinReset    = 8'h6c;

   localparam logic [7:0]  DefaultAttr = 8'h07;
   localparam logic [15:0] NumLimit    = 16'hffff;
   localparam logic [15:0] CursorMode  = 16'd25;
   localparam logic [15:0] EraseAll    = 16'd2;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic [7:0] read_column;
      logic [5:0] read_line;
   } req_type;

   typedef struct packed {
      logic [5:0] cursor_line;
      logic [7:0] cursor_column;
      logic [7:0] current_attr;
      logic       cursor_shown;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } rsp_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] attr;
   } cell_type;

   typedef struct packed {
      logic                en;
      logic [AddrBits-1:0] addr;
      cell_type            data;
   } store_wr_type;

   function automatic logic [AddrBits-1:0] cell_addr(input logic [5:0] row,
                                                     input logic [7:0] col);
      return AddrBits'(row) * AddrBits'(MaxColumns) + AddrBits'(col);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= Digit0Byte) && (b <= Digit9Byte);
   endfunction

endpackage

// ----- hdl/ate_store.sv -----
module ate_store
   import ate_pkg::*;
(
   input  logic                clock,
   input  store_wr_type        wr,
   input  logic [AddrBits-1:0] rd_addr,
   output cell_type            rd_data
);

   cell_type cells_ff [StoreCells];
   cell_type rd_data_ff;

   // Write one cell
   always_ff @(posedge clock) begin
      if (wr.en) begin
         cells_ff[wr.addr] <= wr.data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ate_num.sv -----
module ate_num
   import ate_pkg::*;
(
   input  logic [15:0] value,
   input  logic [7:0]  digit_byte,
   output logic [15:0] result
);

   logic [7:0]  digit;
   logic [19:0] sum;

   // Accumulate one decimal digit, saturate at the limit
   assign digit  = digit_byte - Digit0Byte;
   assign sum    = 20'({value, 3'b000}) + 20'({value, 1'b0}) + 20'(digit[3:0]);
   assign result = (sum > 20'(NumLimit)) ? NumLimit : sum[15:0];

endmodule

// ----- hdl/ansi_text_terminal.sv -----
// Byte-fed text terminal with a screen store of 64 rows by 160 cells.
// Input channel req_*: op 0 feeds data_byte through the escape parser and
// screen logic, op 1 reads the cell at (read_line, read_column). Each accepted
// transaction yields exactly one transaction on rsp_*, carrying the cursor,
// the current attribute, the cursor flag and, for reads, the cell contents.
// csr_* writes the active column and row counts; write them only when idle.
// One transaction is worked on at a time; req_stall is high until it is done.
// A scroll walks the store through its single read port and single write port,
// reading and then writing each cell to move the rows up, and then blanks
// the last row one active column at a time.
// Erase in display walks the cells it clears one per cycle, erase all
// walks the whole store.
// After reset a clearing pass fills the store with spaces in attribute
// 0x07; req_stall stays high meanwhile, csr writes are taken.
// A finished result waits in the output register while rsp_stall is high,
// and the next transaction can be accepted during that wait.
module ansi_text_terminal
   import ate_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [7:0]              csr_write_data
);

   localparam logic [3:0] StIdle        = 4'd0;
   localparam logic [3:0] StDecode      = 4'd1;
   localparam logic [3:0] StReadWait    = 4'd2;
   localparam logic [3:0] StPrint       = 4'd3;
   localparam logic [3:0] StScrollCheck = 4'd4;
   localparam logic [3:0] StScrollRead  = 4'd5;
   localparam logic [3:0] StScrollWrite = 4'd6;
   localparam logic [3:0] StFill        = 4'd7;
   localparam logic [3:0] StSeqStart    = 4'd8;
   localparam logic [3:0] StNumber      = 4'd9;
   localparam logic [3:0] StExec        = 4'd10;
   localparam logic [3:0] StDone        = 4'd11;

   localparam logic [1:0] EscIdle   = 2'd0;
   localparam logic [1:0] EscAfter  = 2'd1;
   localparam logic [1:0] EscParams = 2'd2;

   logic [3:0]          state_ff, state_in;
   logic [7:0]          cols_ff, cols_in;
   logic [6:0]          rows_ff, rows_in;
   logic [6:0]          row_ff, row_in;
   logic [7:0]          col_ff, col_in;
   logic [7:0]          attr_ff, attr_in;
   logic                shown_ff, shown_in;
   logic [1:0]          esc_ff, esc_in;
   logic [PosBits-1:0]  plen_ff, plen_in;
   logic [7:0]          pbuf_ff [ParamBufferBytes];
   logic                pbuf_we;
   logic [7:0]          byte_ff, byte_in;
   logic [7:0]          pch_ff, pch_in;
   logic [TabBits-1:0]  tab_ff, tab_in;
   logic [7:0]          fin_ff, fin_in;
   logic                priv_ff, priv_in;
   logic [PosBits-1:0]  pos_ff, pos_in;
   logic [15:0]         num_ff, num_in;
   logic                any_ff, any_in;
   logic                phase_ff, phase_in;
   logic [15:0]         y_ff, y_in;
   logic [3:0]          fg_ff, fg_in;
   logic [3:0]          bg_ff, bg_in;
   logic [5:0]          fr_ff, fr_in;
   logic [7:0]          fc_ff, fc_in;
   logic [5:0]          flast_ff, flast_in;
   logic [7:0]          flim_ff, flim_in;
   logic [7:0]          fattr_ff, fattr_in;
   logic [3:0]          fret_ff, fret_in;
   logic [AddrBits-1:0] mv_ff, mv_in;
   logic [AddrBits-1:0] mvend_ff, mvend_in;
   cell_type            cell_ff, cell_in;
   logic                rdok_ff, rdok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [7:0]          cols_w;
   logic [6:0]          rows_w;
   logic [6:0]          rows_m1;
   logic [7:0]          cur_byte;
   logic                in_range;
   logic                cur_digit;
   logic                cur_semi;
   logic [15:0]         num_next;
   logic [15:0]         n_one;
   logic [15:0]         n_zero;
   logic [16:0]         row_up;
   logic [16:0]         col_up;
   logic [15:0]         y_m1;
   logic [15:0]         x_m1;
   logic [3:0]          fg_n;
   logic [3:0]          bg_n;
   store_wr_type        wr;
   logic [AddrBits-1:0] rd_addr;
   cell_type            rd_data;

   ate_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ate_num u_num (
      .value      (num_ff),
      .digit_byte (cur_byte),
      .result     (num_next)
   );

   // Saturate the active geometry
   assign cols_w = (cols_ff < 8'(MinColumns)) ? 8'(MinColumns) :
                   (cols_ff > 8'(MaxColumns)) ? 8'(MaxColumns) : cols_ff;
   assign rows_w = (rows_ff < 7'(MinRows)) ? 7'(MinRows) :
                   (rows_ff > 7'(MaxRows)) ? 7'(MaxRows) : rows_ff;
   assign rows_m1 = rows_w - 7'd1;

   // Parameter buffer scan
   assign cur_byte  = pbuf_ff[pos_ff];
   assign in_range  = pos_ff < plen_ff;
   assign cur_digit = in_range && is_digit(cur_byte);
   assign cur_semi  = in_range && (cur_byte == SemiByte);

   assign n_one  = any_ff ? num_ff : 16'd1;
   assign n_zero = any_ff ? num_ff : 16'd0;
   assign row_up = 17'(row_ff) + 17'(n_one);
   assign col_up = 17'(col_ff) + 17'(n_one);
   assign y_m1   = (y_ff <= 16'd1) ? 16'd0 : y_ff - 16'd1;
   assign x_m1   = (n_one <= 16'd1) ? 16'd0 : n_one - 16'd1;

   // Apply one SGR code to the working colors
   always_comb begin
      fg_n = fg_ff;
      bg_n = bg_ff;
      if (n_zero == 16'd0) begin
         fg_n = 4'd7;
         bg_n = 4'd0;
      end else if (n_zero == 16'd1 && fg_ff < 4'd8) begin
         fg_n = fg_ff + 4'd8;
      end else if (n_zero == 16'd7) begin
         fg_n = bg_ff;
         bg_n = fg_ff;
      end else if (n_zero inside {[16'd30:16'd37]}) begin
         fg_n = 4'(n_zero - 16'd30);
      end else if (n_zero inside {[16'd40:16'd47]}) begin
         bg_n = 4'(n_zero - 16'd40);
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      attr_in      = attr_ff;
      shown_in     = shown_ff;
      esc_in       = esc_ff;
      plen_in      = plen_ff;
      pbuf_we      = 1'b0;
      byte_in      = byte_ff;
      pch_in       = pch_ff;
      tab_in       = tab_ff;
      fin_in       = fin_ff;
      priv_in      = priv_ff;
      pos_in       = pos_ff;
      num_in       = num_ff;
      any_in       = any_ff;
      phase_in     = phase_ff;
      y_in         = y_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      fr_in        = fr_ff;
      fc_in        = fc_ff;
      flast_in     = flast_ff;
      flim_in      = flim_ff;
      fattr_in     = fattr_ff;
      fret_in      = fret_ff;
      mv_in        = mv_ff;
      mvend_in     = mvend_ff;
      cell_in      = cell_ff;
      rdok_in      = rdok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr           = '0;
      rd_addr      = cell_addr(req_data.read_line, req_data.read_column);

      // Drop the output once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            CsrColumns: cols_in = csr_write_data;
            CsrRows:    rows_in = csr_write_data[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cell_in = '0;
               rdok_in = 1'b0;
               if (req_data.op) begin
                  rdok_in  = req_data.read_column < 8'(MaxColumns);
                  state_in = StReadWait;
               end else begin
                  byte_in  = req_data.data_byte;
                  state_in = StDecode;
               end
            end
         end

         StReadWait: begin
            if (rdok_ff) begin
               cell_in = rd_data;
            end
            state_in = StDone;
         end

         StDecode: begin
            case (esc_ff)
               EscAfter: begin
                  esc_in   = (byte_ff == BracketByte) ? EscParams : EscIdle;
                  plen_in  = '0;
                  state_in = StDone;
               end
               EscParams: begin
                  if (is_digit(byte_ff) || byte_ff == SemiByte || byte_ff == QuestByte) begin
                     if (plen_ff != PosBits'(ParamBufferBytes - 1)) begin
                        pbuf_we = 1'b1;
                        plen_in = plen_ff + PosBits'(1);
                     end
                     state_in = StDone;
                  end else begin
                     fin_in   = byte_ff;
                     esc_in   = EscIdle;
                     state_in = StSeqStart;
                  end
               end
               default: begin
                  tab_in   = '0;
                  state_in = StScrollCheck;
                  if (byte_ff == EscByte) begin
                     esc_in   = EscAfter;
                     plen_in  = '0;
                     state_in = StDone;
                  end else if (byte_ff == LfByte) begin
                     col_in = '0;
                     row_in = row_ff + 7'd1;
                  end else if (byte_ff == CrByte) begin
                     col_in = '0;
                  end else if (byte_ff == BsByte) begin
                     if (col_ff != 8'd0) begin
                        col_in = col_ff - 8'd1;
                        if ((col_ff - 8'd1) < cols_w && row_ff < rows_w) begin
                           wr.en   = 1'b1;
                           wr.addr = cell_addr(row_ff[5:0], col_ff - 8'd1);
                           wr.data = '{ch: SpaceByte, attr: attr_ff};
                        end
                     end
                  end else if (byte_ff == TabByte) begin
                     pch_in   = SpaceByte;
                     tab_in   = TabBits'(TabSpaces);
                     state_in = StPrint;
                  end else begin
                     pch_in   = byte_ff;
                     tab_in   = TabBits'(1);
                     state_in = StPrint;
                  end
               end
            endcase
         end

         StPrint: begin
            if (col_ff < cols_w && row_ff < rows_w) begin
               wr.en   = 1'b1;
               wr.addr = cell_addr(row_ff[5:0], col_ff);
               wr.data = '{ch: pch_ff, attr: attr_ff};
            end
            if ((9'(col_ff) + 9'd1) >= 9'(cols_w)) begin
               col_in = '0;
               row_in = row_ff + 7'd1;
            end else begin
               col_in = col_ff + 8'd1;
            end
            tab_in   = tab_ff - TabBits'(1);
            state_in = StScrollCheck;
         end

         StScrollCheck: begin
            if (row_ff >= rows_w) begin
               mv_in    = '0;
               mvend_in = cell_addr(rows_m1[5:0], 8'd0);
               row_in   = rows_m1;
               state_in = StScrollRead;
            end else if (tab_ff != '0) begin
               state_in = StPrint;
            end else begin
               state_in = StDone;
            end
         end

         StScrollRead: begin
            rd_addr  = mv_ff + AddrBits'(MaxColumns);
            state_in = StScrollWrite;
         end

         StScrollWrite: begin
            wr.en   = 1'b1;
            wr.addr = mv_ff;
            wr.data = rd_data;
            if ((mv_ff + AddrBits'(1)) == mvend_ff) begin
               fr_in    = rows_m1[5:0];
               fc_in    = '0;
               flast_in = rows_m1[5:0];
               flim_in  = cols_w;
               fattr_in = attr_ff;
               fret_in  = StScrollCheck;
               state_in = StFill;
            end else begin
               mv_in    = mv_ff + AddrBits'(1);
               state_in = StScrollRead;
            end
         end

         StFill: begin
            if (fc_ff < flim_ff) begin
               wr.en   = 1'b1;
               wr.addr = cell_addr(fr_ff, fc_ff);
               wr.data = '{ch: SpaceByte, attr: fattr_ff};
            end
            if ((9'(fc_ff) + 9'd1) >= 9'(flim_ff)) begin
               fc_in = '0;
               if (fr_ff == flast_ff) begin
                  state_in = fret_ff;
               end else begin
                  fr_in = fr_ff + 6'd1;
               end
            end else begin
               fc_in = fc_ff + 8'd1;
            end
         end

         StSeqStart: begin
            priv_in  = (plen_ff != '0) && (pbuf_ff[0] == QuestByte);
            pos_in   = priv_in ? PosBits'(1) : '0;
            num_in   = '0;
            any_in   = 1'b0;
            phase_in = 1'b0;
            fg_in    = attr_ff[3:0];
            bg_in    = attr_ff[7:4];
            if (fin_ff == FinSgr && pos_in >= plen_ff) begin
               attr_in  = DefaultAttr;
               plen_in  = '0;
               state_in = StDone;
            end else begin
               state_in = StNumber;
            end
         end

         StNumber: begin
            if (cur_digit) begin
               num_in = num_next;
               any_in = 1'b1;
               pos_in = pos_ff + PosBits'(1);
            end else begin
               state_in = StExec;
            end
         end

         StExec: begin
            plen_in  = '0;
            state_in = StDone;
            case (fin_ff)
               FinUp: begin
                  row_in = (n_one > 16'(row_ff)) ? 7'd0 : 7'(16'(row_ff) - n_one);
               end
               FinDown: begin
                  row_in = (row_up >= 17'(rows_w)) ? rows_m1 : row_up[6:0];
               end
               FinRight: begin
                  col_in = (col_up >= 17'(cols_w)) ? (cols_w - 8'd1) : col_up[7:0];
               end
               FinLeft: begin
                  col_in = (n_one > 16'(col_ff)) ? 8'd0 : 8'(16'(col_ff) - n_one);
               end
               FinHome, FinHomeAlt: begin
                  if (!phase_ff) begin
                     y_in     = n_one;
                     pos_in   = cur_semi ? pos_ff + PosBits'(1) : pos_ff;
                     num_in   = '0;
                     any_in   = 1'b0;
                     phase_in = 1'b1;
                     plen_in  = plen_ff;
                     state_in = StNumber;
                  end else begin
                     row_in = (y_m1 >= 16'(rows_w)) ? rows_m1 : y_m1[6:0];
                     col_in = (x_m1 >= 16'(cols_w)) ? (cols_w - 8'd1) : x_m1[7:0];
                  end
               end
               FinEraseDsp: begin
                  if (n_zero == EraseAll) begin
                     fr_in    = '0;
                     fc_in    = '0;
                     flast_in = 6'(MaxRows - 1);
                     flim_in  = 8'(MaxColumns);
                     fattr_in = attr_ff;
                     fret_in  = StDone;
                     row_in   = '0;
                     col_in   = '0;
                     state_in = StFill;
                  end else if (row_ff < rows_w) begin
                     fr_in    = row_ff[5:0];
                     fc_in    = col_ff;
                     flast_in = rows_m1[5:0];
                     flim_in  = cols_w;
                     fattr_in = attr_ff;
                     fret_in  = StDone;
                     state_in = StFill;
                  end
               end
               FinEraseLn: begin
                  if (row_ff < rows_w) begin
                     fr_in    = row_ff[5:0];
                     fc_in    = col_ff;
                     flast_in = row_ff[5:0];
                     flim_in  = cols_w;
                     fattr_in = attr_ff;
                     fret_in  = StDone;
                     state_in = StFill;
                  end
               end
               FinSgr: begin
                  attr_in = {bg_n, fg_n};
                  if (cur_semi) begin
                     pos_in = pos_ff + PosBits'(1);
                     if ((6'(pos_ff) + 6'd1) < 6'(plen_ff)) begin
                        attr_in  = attr_ff;
                        fg_in    = fg_n;
                        bg_in    = bg_n;
                        num_in   = '0;
                        any_in   = 1'b0;
                        plen_in  = plen_ff;
                        state_in = StNumber;
                     end
                  end
               end
               FinSet: begin
                  if (priv_ff && n_zero == CursorMode) begin
                     shown_in = 1'b1;
                  end
               end
               FinReset: begin
                  if (priv_ff && n_zero == CursorMode) begin
                     shown_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end

         StDone: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.cursor_line   = row_ff[5:0];
               rsp_in.cursor_column = col_ff;
               rsp_in.current_attr  = attr_ff;
               rsp_in.cursor_shown  = shown_ff;
               rsp_in.cell_char     = cell_ff.ch;
               rsp_in.cell_attr     = cell_ff.attr;
               rsp_valid_in         = 1'b1;
               state_in             = StIdle;
            end
         end

         default: state_in = StIdle;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StFill;
         cols_ff      <= 8'd80;
         rows_ff      <= 7'd25;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= DefaultAttr;
         shown_ff     <= 1'b1;
         esc_ff       <= EscIdle;
         plen_ff      <= '0;
         tab_ff       <= '0;
         phase_ff     <= 1'b0;
         fr_ff        <= '0;
         fc_ff        <= '0;
         flast_ff     <= 6'(MaxRows - 1);
         flim_ff      <= 8'(MaxColumns);
         fattr_ff     <= DefaultAttr;
         fret_ff      <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         shown_ff     <= shown_in;
         esc_ff       <= esc_in;
         plen_ff      <= plen_in;
         tab_ff       <= tab_in;
         phase_ff     <= phase_in;
         fr_ff        <= fr_in;
         fc_ff        <= fc_in;
         flast_ff     <= flast_in;
         flim_ff      <= flim_in;
         fattr_ff     <= fattr_in;
         fret_ff      <= fret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      pch_ff   <= pch_in;
      fin_ff   <= fin_in;
      priv_ff  <= priv_in;
      pos_ff   <= pos_in;
      num_ff   <= num_in;
      any_ff   <= any_in;
      y_ff     <= y_in;
      fg_ff    <= fg_in;
      bg_ff    <= bg_in;
      mv_ff    <= mv_in;
      mvend_ff <= mvend_in;
      cell_ff  <= cell_in;
      rdok_ff  <= rdok_in;
      rsp_ff   <= rsp_in;
      if (pbuf_we) begin
         pbuf_ff[plen_ff] <= byte_ff;
      end
   end

   assign req_stall = (state_ff != StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/ate_checker.sv -----
`include "ansi_text_terminal_defines.svh"

module ate_checker
   import ate_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // One transaction in flight: stall right after each acceptance
   `ATE_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

   // A stalled result stays put
   `ATE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Cursor column never leaves the store
   `ATE_ASSERT_NOW(a_col_range, rsp_valid, rsp_data.cursor_column < 8'(MaxColumns))

   // No result straight out of reset
   `ATE_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_valid)

endmodule

bind ansi_text_terminal ate_checker u_ate_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/tb_top.sv -----
module tb_top;
   import ate_pkg::*;

   localparam logic OpFeed = 1'b0;
   localparam logic OpRead = 1'b1;
   localparam int   CycleLimit = 60000000;
   localparam int   PhaseItems = 105;

   // Shadow terminal: screen store, cursor, parser and expected responses
   class screen_scoreboard;
      byte unsigned chars[StoreCells];
      byte unsigned attrs[StoreCells];
      int unsigned  row, col, plen, cols_reg, rows_reg;
      byte unsigned attr, pbuf[ParamBufferBytes];
      bit           shown;
      int           esc_phase;
      rsp_type      pending[$];
      int           errors, checked;

      function new();
         foreach (chars[i]) begin
            chars[i] = SpaceByte;
            attrs[i] = DefaultAttr;
         end
         row = 0; col = 0; attr = DefaultAttr; shown = 1;
         esc_phase = 0; plen = 0; cols_reg = 80; rows_reg = 25;
         errors = 0; checked = 0;
      endfunction

      function void configure(logic [0:0] idx, int unsigned val);
         if (idx == CsrColumns) cols_reg = val & 8'hff;
         else rows_reg = val & 7'h7f;
      endfunction

      function int unsigned ncols();
         return cols_reg < MinColumns ? MinColumns : (cols_reg > MaxColumns ? MaxColumns : cols_reg);
      endfunction

      function int unsigned nrows();
         return rows_reg < MinRows ? MinRows : (rows_reg > MaxRows ? MaxRows : rows_reg);
      endfunction

      function void set_cell(int unsigned c, int unsigned r, byte unsigned ch);
         if (c < ncols() && r < nrows()) begin
            chars[r * MaxColumns + c] = ch;
            attrs[r * MaxColumns + c] = attr;
         end
      endfunction

      // Shift rows up by one and blank the last active row
      function void scroll();
         int unsigned rows;
         rows = nrows();
         if (row < rows) return;
         for (int i = 0; i < (rows - 1) * MaxColumns; i++) begin
            chars[i] = chars[i + MaxColumns];
            attrs[i] = attrs[i + MaxColumns];
         end
         for (int x = 0; x < ncols(); x++) begin
            chars[(rows - 1) * MaxColumns + x] = SpaceByte;
            attrs[(rows - 1) * MaxColumns + x] = attr;
         end
         row = rows - 1;
      endfunction

      function void print(byte unsigned ch);
         set_cell(col, row, ch);
         col++;
         if (col >= ncols()) begin
            col = 0;
            row++;
         end
         scroll();
      endfunction

      function void clear_line();
         for (int unsigned x = col; x < ncols(); x++) set_cell(x, row, SpaceByte);
      endfunction

      function bit at_byte(int unsigned pos, byte unsigned b);
         return pos < plen && pos < ParamBufferBytes && pbuf[pos] == b;
      endfunction

      // Decimal number from the parameter buffer, saturating
      function int unsigned parse_num(inout int unsigned pos, input int unsigned dflt);
         int unsigned v;
         bit any;
         v = 0; any = 0;
         while (pos < plen && pos < ParamBufferBytes && is_digit(pbuf[pos])) begin
            any = 1;
            v = v * 10 + (pbuf[pos] - Digit0Byte);
            if (v > NumLimit) v = NumLimit;
            pos++;
         end
         return any ? v : dflt;
      endfunction

      function void sgr(int unsigned pos);
         int unsigned fg, bg, code, t;
         fg = attr & 8'h0f;
         bg = (attr >> 4) & 8'h0f;
         if (pos >= plen) begin
            attr = DefaultAttr;
            return;
         end
         while (pos < plen) begin
            code = parse_num(pos, 0);
            if (code == 0) begin
               fg = 7; bg = 0;
            end else if (code == 1 && fg < 8) begin
               fg += 8;
            end else if (code == 7) begin
               t = fg; fg = bg; bg = t;
            end else if (code >= 30 && code <= 37) begin
               fg = code - 30;
            end else if (code >= 40 && code <= 47) begin
               bg = code - 40;
            end
            if (at_byte(pos, SemiByte)) pos++;
            else break;
         end
         attr = (fg & 8'h0f) | ((bg & 8'h0f) << 4);
      endfunction

      function void run_sequence(byte unsigned fin);
         int unsigned pos, n, y, x, rows, cols;
         bit priv;
         pos = 0; rows = nrows(); cols = ncols(); priv = 0;
         if (at_byte(0, QuestByte)) begin
            priv = 1; pos = 1;
         end
         case (fin)
            FinUp: begin
               n = parse_num(pos, 1);
               row = n > row ? 0 : row - n;
            end
            FinDown: begin
               n = parse_num(pos, 1);
               row += n;
               if (row >= rows) row = rows - 1;
            end
            FinRight: begin
               n = parse_num(pos, 1);
               col += n;
               if (col >= cols) col = cols - 1;
            end
            FinLeft: begin
               n = parse_num(pos, 1);
               col = n > col ? 0 : col - n;
            end
            FinHome, FinHomeAlt: begin
               y = parse_num(pos, 1);
               if (at_byte(pos, SemiByte)) pos++;
               x = parse_num(pos, 1);
               row = y <= 1 ? 0 : y - 1;
               col = x <= 1 ? 0 : x - 1;
               if (row >= rows) row = rows - 1;
               if (col >= cols) col = cols - 1;
            end
            FinEraseDsp: begin
               if (parse_num(pos, 0) == EraseAll) begin
                  foreach (chars[i]) begin
                     chars[i] = SpaceByte;
                     attrs[i] = attr;
                  end
                  row = 0; col = 0;
               end else begin
                  clear_line();
                  for (y = row + 1; y < rows; y++)
                     for (x = 0; x < cols; x++) set_cell(x, y, SpaceByte);
               end
            end
            FinEraseLn: clear_line();
            FinSgr: sgr(pos);
            FinSet: if (priv && parse_num(pos, 0) == CursorMode) shown = 1;
            FinReset: if (priv && parse_num(pos, 0) == CursorMode) shown = 0;
            default: ;
         endcase
      endfunction

      function void feed(byte unsigned b);
         if (esc_phase == 1) begin
            esc_phase = (b == BracketByte) ? 2 : 0;
            plen = 0;
            return;
         end
         if (esc_phase != 0) begin
            if (is_digit(b) || b == SemiByte || b == QuestByte) begin
               if (plen + 1 < ParamBufferBytes) pbuf[plen++] = b;
               return;
            end
            run_sequence(b);
            esc_phase = 0; plen = 0;
            return;
         end
         case (b)
            EscByte: begin
               esc_phase = 1; plen = 0;
            end
            LfByte: begin
               col = 0; row++; scroll();
            end
            CrByte: begin
               col = 0; scroll();
            end
            BsByte: begin
               if (col > 0) begin
                  col--;
                  set_cell(col, row, SpaceByte);
               end
               scroll();
            end
            TabByte: for (int i = 0; i < TabSpaces; i++) print(SpaceByte);
            default: print(b);
         endcase
      endfunction

      // Note an accepted request and queue the response it must produce
      function void note(req_type rq);
         rsp_type rs;
         rs = '0;
         if (rq.op == OpRead) begin
            if (rq.read_column < MaxColumns) begin
               rs.cell_char = chars[rq.read_line * MaxColumns + rq.read_column];
               rs.cell_attr = attrs[rq.read_line * MaxColumns + rq.read_column];
            end
         end else begin
            feed(rq.data_byte);
         end
         rs.cursor_line   = row[5:0];
         rs.cursor_column = col[7:0];
         rs.current_attr  = attr;
         rs.cursor_shown  = shown;
         pending.push_back(rs);
      endfunction

      function void compare(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch expected 0x%0h actual 0x%0h", $time, name, e, a);
         end
      endfunction

      function void check(rsp_type rs);
         rsp_type ex;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response expected none actual 0x%0h", $time, rs);
            return;
         end
         ex = pending.pop_front();
         checked++;
         compare("cursor_line", ex.cursor_line, rs.cursor_line);
         compare("cursor_column", ex.cursor_column, rs.cursor_column);
         compare("current_attr", ex.current_attr, rs.current_attr);
         compare("cursor_shown", ex.cursor_shown, rs.cursor_shown);
         compare("cell_char", ex.cell_char, rs.cell_char);
         compare("cell_attr", ex.cell_attr, rs.cell_attr);
      endfunction
   endclass

   logic              clock, reset;
   logic              req_valid, req_stall, rsp_valid, rsp_stall;
   req_type           req_data;
   rsp_type           rsp_data;
   logic              csr_write_enable;
   logic [CsrIndexBits-1:0] csr_index;
   logic [7:0]        csr_write_data;

   screen_scoreboard  sb;
   req_type           stim[$];
   int                cycles;
   bit                long_hold;
   int                settings_done;

   ansi_text_terminal DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Check each response transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
   end

   // Receiver stall pattern: runs of random density, plus one long hold-off
   initial begin
      int run_len, density;
      rsp_stall = 0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         run_len = $urandom_range(5, 60);
         case ($urandom_range(0, 2))
            0: density = 0;
            1: density = 30;
            default: density = 75;
         endcase
         repeat (run_len) begin
            rsp_stall <= ($urandom_range(0, 99) < density);
            @(negedge clock);
         end
      end
   end

   function automatic req_type make_byte(byte unsigned b);
      req_type rq;
      rq.op = OpFeed;
      rq.data_byte = b;
      rq.read_column = 8'($urandom_range(0, 255));
      rq.read_line = 6'($urandom_range(0, 63));
      return rq;
   endfunction

   task automatic push_byte(byte unsigned b);
      stim.push_back(make_byte(b));
   endtask

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_read(int c, int l);
      req_type rq;
      rq.op = OpRead;
      rq.data_byte = 8'($urandom_range(0, 255));
      rq.read_column = 8'(c);
      rq.read_line = 6'(l);
      stim.push_back(rq);
   endtask

   function automatic int unsigned pick_num();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 9);
         1: return CursorMode;
         2: return $urandom_range(30, 47);
         3: return $urandom_range(0, 99);
         4: return $urandom_range(0, 200);
         default: return $urandom;
      endcase
   endfunction

   // One random escape sequence, mostly well formed
   task automatic push_escape();
      byte unsigned finals[11];
      int n;
      finals = '{FinUp, FinDown, FinRight, FinLeft, FinHome, FinHomeAlt,
                 FinEraseDsp, FinEraseLn, FinSgr, FinSet, FinReset};
      push_byte(EscByte);
      push_byte(BracketByte);
      if ($urandom_range(0, 4) == 0) push_byte(QuestByte);
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
         if (k > 0) push_byte(SemiByte);
         if ($urandom_range(0, 4) != 0) push_str($sformatf("%0d", pick_num()));
      end
      if ($urandom_range(0, 30) == 0)
         repeat (35) push_byte(8'(Digit0Byte + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(finals[$urandom_range(0, 10)]);
   endtask

   task automatic build_random(int count);
      int stop;
      stop = stim.size() + count;
      while (stim.size() < stop) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
               repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(8'h20, 8'h7e)));
            6: push_byte(8'($urandom_range(0, 255)));
            7: push_byte(LfByte);
            8: push_byte(CrByte);
            9: push_byte(BsByte);
            10: push_byte(TabByte);
            11, 12, 13, 14, 15: push_escape();
            16, 17: push_read($urandom_range(0, 255), $urandom_range(0, 63));
            18: push_read(sb.col + $urandom_range(0, 3), sb.row);
            default: begin
               push_byte(EscByte);
               push_byte(8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   // Drive queued requests in bursts with random gaps
   task automatic drive_all();
      req_type it;
      int burst, gap;
      burst = 0;
      while (stim.size() > 0) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 0;
               repeat (gap) @(negedge clock);
            end
         end
         it = stim.pop_front();
         req_valid <= 1;
         req_data <= it;
         do @(posedge clock); while (req_stall);
         sb.note(it);
         burst--;
         @(negedge clock);
      end
      req_valid <= 0;
   endtask

   task automatic drain();
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_geometry(int unsigned c, int unsigned r);
      csr_write_enable <= 1;
      csr_index <= CsrColumns;
      csr_write_data <= 8'(c);
      sb.configure(CsrColumns, c);
      @(negedge clock);
      csr_index <= CsrRows;
      csr_write_data <= 8'(r);
      sb.configure(CsrRows, r);
      @(negedge clock);
      csr_write_enable <= 0;
      @(negedge clock);
      settings_done++;
   endtask

   initial begin
      int unsigned geo_c[6], geo_r[6];
      sb = new();
      cycles = 0; long_hold = 0; settings_done = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_write_enable = 0;
      csr_index = CsrColumns;
      csr_write_data = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset state, controls, every final, saturation, overflow
      push_read(0, 0);
      push_read(159, 63);
      push_read(200, 5);
      push_byte(8'hff);
      push_byte(8'h00);
      push_byte(TabByte);
      push_byte(BsByte);
      push_byte(CrByte);
      push_byte(BsByte);
      push_byte(LfByte);
      push_str("\033x");
      push_str("\033[5;10H");
      push_str("\033[0A\033[A\033[99B\033[C\033[3D\033[0D");
      push_str("\033[1;7;31;42m\033[99;1m\033[m");
      push_str("\033[?25l\033[25h\033[?25h\033[K\033[J");
      push_str("\033[99999999C\033[3;4f\033[Z");
      push_str("\033[");
      repeat (40) push_byte(Digit9Byte);
      push_byte(FinUp);
      push_str("\033[2J");
      push_read(3, 2);
      build_random(PhaseItems);
      drive_all();
      drain();

      // Long receiver hold-off while the next phase keeps offering items
      long_hold = 1;
      geo_c = '{20, 160, 255, 0, 120, 30};
      geo_r = '{8, 64, 127, 0, 40, 10};
      foreach (geo_c[i]) begin
         write_geometry(geo_c[i], geo_r[i]);
         build_random(PhaseItems);
         drive_all();
         drain();
      end

      repeat (50) @(negedge clock);
      if (sb.pending.size() > 0) begin
         sb.errors++;
         $display("%0t: %0d responses never arrived", $time, sb.pending.size());
      end
      $display("Checked %0d response transactions over %0d geometry settings plus reset",
               sb.checked, settings_done);
      $display("Covered controls, escape finals, SGR, cursor mode, scroll and reads");
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
